>>> rtl/wtcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtcp_pkg
// Types and constants shared by the wake target CPU picker.
// ----------------------------------------------------------------------------
package wtcp_pkg;

    localparam int DEF_MAX_CPUS  = 64;
    localparam int DEF_LOAD_BITS = 16;

    localparam int CPU_W     = 6;
    localparam int LAST_W    = 7;
    localparam int LOAD_IN_W = 16;
    localparam int MASK_W    = 64;
    localparam int COUNT_W   = 7;
    localparam int SLOP_W    = 8;
    localparam int CURSOR_W  = 32;
    localparam int REASON_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PICK = 1'b1;

    localparam logic [REASON_W-1:0] REASON_LOCAL = 2'd0;
    localparam logic [REASON_W-1:0] REASON_IDLE  = 2'd1;
    localparam logic [REASON_W-1:0] REASON_LOAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CPU_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_SLOP   = 2'd2;

    localparam logic [COUNT_W-1:0]   RST_CPU_COUNT = 7'd1;
    localparam logic [MASK_W-1:0]    RST_ONLINE    = 64'd1;
    localparam logic [SLOP_W-1:0]    RST_SLOP      = 8'd1;

    typedef struct packed {
        logic                 func;
        logic [CPU_W-1:0]     cpu_index;
        logic [LOAD_IN_W-1:0] load_value;
        logic                 thread_present;
        logic [MASK_W-1:0]    allowed_mask;
        logic [LAST_W-1:0]    prev_cpu;
    } t_pick_in;

    typedef struct packed {
        logic [CPU_W-1:0]    dest_cpu;
        logic [REASON_W-1:0] wake_cause;
    } t_pick_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_NEAR,
        S_MOD,
        S_RR
    } t_state;

endpackage

>>> rtl/wake_target_cpu_picker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wake_target_cpu_picker_unit
// Chooses the CPU for a woken thread from a table of per-CPU loads.
// ----------------------------------------------------------------------------
// Usage: a word on i_in is taken when i_start is high and o_busy is low.
// A load-update word (func 0) writes the load table in that cycle, gives no
// result and leaves the unit ready again in the next cycle. A pick word
// (func 1) raises o_busy and gives exactly one result on o_res, marked by
// o_res_valid for a single cycle; o_busy is already low in that cycle.
// A pick keeps o_busy high for the load scan and decision, and then for
// the search for an idle CPU, or for the round-robin choice, which forms
// the bit-serial remainder of the cursor by n, the clamped CPU count, and
// then steps from it to an allowed CPU of least load. The load memory is
// read one entry per cycle during the scan. The configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) is always ready.
// It is to be written by the user only while the unit is idle; the unit
// itself does not enforce this.
// Reset clears the configuration to its defaults, marks every table entry
// as idle by clearing its valid bit, and zeroes the round-robin cursor.
// The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module wake_target_cpu_picker_unit #(
    parameter int MAX_CPUS  = wtcp_pkg::DEF_MAX_CPUS,
    parameter int LOAD_BITS = wtcp_pkg::DEF_LOAD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  wtcp_pkg::t_pick_in            i_in,
    output logic                          o_res_valid,
    output wtcp_pkg::t_pick_res           o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wtcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wtcp_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import wtcp_pkg::*;

    localparam int LW = (LOAD_BITS < 16) ? LOAD_BITS : 16;
    localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int SW = LW + SLOP_W + 1;
    localparam logic [LOAD_IN_W-1:0] LOAD_LIM =
        (LOAD_BITS < 16) ? LOAD_IN_W'((32'd1 << LOAD_BITS) - 32'd1) : 16'hFFFF;
    localparam logic [COUNT_W-1:0] N_MAX = COUNT_W'(MAX_CPUS);
    localparam logic [COUNT_W-1:0] MOD_LAST = COUNT_W'(CURSOR_W - 1);

    t_state r_state, n_state;

    logic [COUNT_W-1:0]  r_cpu_count;
    logic [MASK_W-1:0]   r_online;
    logic [SLOP_W-1:0]   r_slop;

    logic [LW-1:0]       mem [MAX_CPUS];
    logic [LW-1:0]       r_rdata;
    logic [MAX_CPUS-1:0] r_vld;

    logic [COUNT_W-1:0]  r_n, n_n;
    logic [MASK_W-1:0]   r_allowed, n_allowed;
    logic [LAST_W-1:0]   r_last, n_last;
    logic                r_present, n_present;
    logic [COUNT_W-1:0]  r_rd_cnt, n_rd_cnt;
    logic                r_pv, n_pv;
    logic [CPU_W-1:0]    r_pcpu, n_pcpu;
    logic                r_found, n_found;
    logic [LW-1:0]       r_min, n_min;
    logic [MASK_W-1:0]   r_minm, n_minm;
    logic [MASK_W-1:0]   r_idlem, n_idlem;
    logic [CPU_W-1:0]    r_first, n_first;
    logic [LW-1:0]       r_pref_load, n_pref_load;
    logic [CPU_W-1:0]    r_base, n_base;
    logic [COUNT_W-1:0]  r_cnt, n_cnt;
    logic                r_have, n_have;
    logic [CPU_W-1:0]    r_best, n_best;
    logic [COUNT_W-1:0]  r_best_d, n_best_d;
    logic [CURSOR_W-1:0] r_cursor, n_cursor;
    logic [CURSOR_W-1:0] r_div, n_div;
    logic [COUNT_W-1:0]  r_rem, n_rem;
    logic                r_res_valid, n_res_valid;
    t_pick_res           r_res, n_res;

    logic                accept;
    logic                mem_we;
    logic [LW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic                scan_issue;
    logic                scan_done;
    logic                pref_ok;
    logic                local_ok;
    logic                near_last;
    logic                rr_hit;
    logic [LW-1:0]       scan_ld;
    logic [CPU_W-1:0]    near_dd;
    logic [COUNT_W-1:0]  near_oth;
    logic [COUNT_W-1:0]  near_d;
    logic [COUNT_W:0]    mod_sh;
    logic [COUNT_W:0]    mod_sub;
    logic [COUNT_W-1:0]  pick_n;
    logic [MASK_W-1:0]   pick_a;
    logic [MASK_W-1:0]   pick_b;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign mem_we    = accept && (i_in.func == FUNC_LOAD)
                       && ({1'b0, i_in.cpu_index} < N_MAX);
    assign mem_wdata = (i_in.load_value > LOAD_LIM) ? LW'(LOAD_LIM) : LW'(i_in.load_value);
    assign mem_raddr = r_rd_cnt[AW-1:0];

    assign scan_issue = (r_rd_cnt < r_n);
    assign scan_done  = !scan_issue && !r_pv;
    assign scan_ld    = r_vld[r_pcpu[AW-1:0]] ? r_rdata : '0;

    assign pref_ok  = r_present && (r_last < r_n) && r_allowed[r_last[CPU_W-1:0]];
    assign local_ok = pref_ok
                      && (SW'(r_pref_load) <= (SW'(r_min) + SW'(r_slop)));

    assign near_dd   = (r_base > r_cnt[CPU_W-1:0]) ? (r_base - r_cnt[CPU_W-1:0])
                                                   : (r_cnt[CPU_W-1:0] - r_base);
    assign near_oth  = r_n - {1'b0, near_dd};
    assign near_d    = (near_oth < {1'b0, near_dd}) ? near_oth : {1'b0, near_dd};
    assign near_last = (r_cnt == (r_n - COUNT_W'(1)));

    assign mod_sh  = {r_rem, r_div[CURSOR_W-1]};
    assign mod_sub = mod_sh - {1'b0, r_n};
    assign rr_hit  = r_minm[r_rem[CPU_W-1:0]];

    assign pick_n = (r_cpu_count > N_MAX) ? N_MAX
                  : ((r_cpu_count == '0) ? COUNT_W'(1) : r_cpu_count);
    assign pick_a = (i_in.thread_present ? i_in.allowed_mask : '0) & r_online;
    assign pick_b = (pick_a != '0) ? pick_a
                  : ((r_online != '0) ? r_online : MASK_W'(1));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_in.cpu_index[AW-1:0]] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[i_in.cpu_index[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count <= RST_CPU_COUNT;
            r_online    <= RST_ONLINE;
            r_slop      <= RST_SLOP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CPU_COUNT:   r_cpu_count <= i_cfg_data[COUNT_W-1:0];
                CFG_ONLINE_MASK: r_online    <= i_cfg_data[MASK_W-1:0];
                CFG_LOAD_SLOP:   r_slop      <= i_cfg_data[SLOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.func == FUNC_PICK)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!r_found || (r_idlem == '0 && local_ok)) begin
                    n_state = S_IDLE;
                end else if (r_idlem != '0) begin
                    n_state = S_NEAR;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_NEAR: begin
                if (near_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MOD: begin
                if (r_cnt == MOD_LAST) begin
                    n_state = S_RR;
                end
            end
            S_RR: begin
                if (rr_hit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_n         = r_n;
        n_allowed   = r_allowed;
        n_last      = r_last;
        n_present   = r_present;
        n_rd_cnt    = r_rd_cnt;
        n_pv        = 1'b0;
        n_pcpu      = r_pcpu;
        n_found     = r_found;
        n_min       = r_min;
        n_minm      = r_minm;
        n_idlem     = r_idlem;
        n_first     = r_first;
        n_pref_load = r_pref_load;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_have      = r_have;
        n_best      = r_best;
        n_best_d    = r_best_d;
        n_cursor    = r_cursor;
        n_div       = r_div;
        n_rem       = r_rem;
        n_res_valid = 1'b0;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.func == FUNC_PICK)) begin
                    n_n       = pick_n;
                    n_allowed = pick_b;
                    n_last    = i_in.prev_cpu;
                    n_present = i_in.thread_present;
                    n_rd_cnt  = '0;
                    n_found   = 1'b0;
                    n_min     = '0;
                    n_minm    = '0;
                    n_idlem   = '0;
                    n_first   = '0;
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    n_rd_cnt = r_rd_cnt + COUNT_W'(1);
                    n_pv     = 1'b1;
                    n_pcpu   = r_rd_cnt[CPU_W-1:0];
                end
                if (r_pv && r_allowed[r_pcpu]) begin
                    if (scan_ld == '0) begin
                        n_idlem[r_pcpu] = 1'b1;
                    end
                    if (!r_found || (scan_ld < r_min)) begin
                        n_min          = scan_ld;
                        n_minm         = '0;
                        n_minm[r_pcpu] = 1'b1;
                        n_first        = r_pcpu;
                        n_found        = 1'b1;
                    end else if (scan_ld == r_min) begin
                        n_minm[r_pcpu] = 1'b1;
                    end
                end
                if (r_pv && ({1'b0, r_pcpu} == r_last)) begin
                    n_pref_load = scan_ld;
                end
            end
            S_PICK: begin
                n_cnt  = '0;
                n_have = 1'b0;
                n_base = pref_ok ? r_last[CPU_W-1:0] : r_first;
                if (!r_found) begin
                    n_res_valid      = 1'b1;
                    n_res.dest_cpu   = '0;
                    n_res.wake_cause = REASON_LOAD;
                end else if (r_idlem == '0 && local_ok) begin
                    n_res_valid      = 1'b1;
                    n_res.dest_cpu   = r_last[CPU_W-1:0];
                    n_res.wake_cause = REASON_LOCAL;
                end else if (r_idlem == '0) begin
                    n_div    = r_cursor;
                    n_rem    = '0;
                    n_cursor = r_cursor + CURSOR_W'(1);
                end
            end
            S_NEAR: begin
                n_cnt = r_cnt + COUNT_W'(1);
                if (r_idlem[r_cnt[CPU_W-1:0]] && (!r_have || (near_d < r_best_d))) begin
                    n_have   = 1'b1;
                    n_best   = r_cnt[CPU_W-1:0];
                    n_best_d = near_d;
                end
                if (near_last) begin
                    n_res_valid      = 1'b1;
                    n_res.dest_cpu   = n_best;
                    n_res.wake_cause = REASON_IDLE;
                end
            end
            S_MOD: begin
                n_cnt = r_cnt + COUNT_W'(1);
                n_div = r_div << 1;
                n_rem = (mod_sh >= {1'b0, r_n}) ? mod_sub[COUNT_W-1:0]
                                                : mod_sh[COUNT_W-1:0];
            end
            S_RR: begin
                if (rr_hit) begin
                    n_res_valid      = 1'b1;
                    n_res.dest_cpu   = r_rem[CPU_W-1:0];
                    n_res.wake_cause = REASON_LOAD;
                end else begin
                    n_rem = ((r_rem + COUNT_W'(1)) == r_n) ? '0 : (r_rem + COUNT_W'(1));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_res_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_rd_cnt    <= '0;
            r_n         <= COUNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_res_valid <= n_res_valid;
            r_pv        <= n_pv;
            r_rd_cnt    <= n_rd_cnt;
            r_n         <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_allowed   <= n_allowed;
        r_last      <= n_last;
        r_present   <= n_present;
        r_pcpu      <= n_pcpu;
        r_found     <= n_found;
        r_min       <= n_min;
        r_minm      <= n_minm;
        r_idlem     <= n_idlem;
        r_first     <= n_first;
        r_pref_load <= n_pref_load;
        r_base      <= n_base;
        r_cnt       <= n_cnt;
        r_have      <= n_have;
        r_best      <= n_best;
        r_best_d    <= n_best_d;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_res       <= n_res;
    end

    a_res_ends_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (!o_busy && $past(o_busy)))
        else $error("Result given outside the end of a pick.");

    a_local_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.wake_cause == REASON_LOCAL))
            |-> (o_res.dest_cpu == r_last[CPU_W-1:0]))
        else $error("Kept-local result does not name the last CPU.");

    a_cursor_moves_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cursor) |-> ($past(r_state) == S_PICK && r_state == S_MOD))
        else $error("Round-robin cursor moved outside a round-robin choice.");

    a_rr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RR) |-> (r_rem < r_n))
        else $error("Round-robin position beyond the CPU count.");

endmodule
